// ----- rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dual stack shared memory block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned CNT_W     = 11;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FIRST  = 3'd0,
    OP_PUSH_SECOND = 3'd1,
    OP_POP_FIRST   = 3'd2,
    OP_POP_SECOND  = 3'd3,
    OP_PEEK_FIRST  = 3'd4,
    OP_PEEK_SECOND = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef struct packed {
    logic             mem_we;
    logic             mem_re;
    logic             has_value;
    logic [CNT_W-1:0] index;
    status_e          status;
    logic [CNT_W-1:0] first_cnt;
    logic [CNT_W-1:0] second_cnt;
  } ptr_resp_t;

endpackage

// ----- rtl/dss_intf.sv -----
// ----------------------------------------------------------------------------
// dss_req_if / dss_rsp_if
// Valid/ready channels carrying operation words and result words.
// ----------------------------------------------------------------------------
interface dss_req_if;
  logic                             valid;
  logic                             ready;
  logic [dss_pkg::OP_W-1:0]         operation;
  logic signed [dss_pkg::VAL_W-1:0] push_value;

  modport source(output valid, operation, push_value, input ready);
  modport sink(input valid, operation, push_value, output ready);
endinterface

interface dss_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [dss_pkg::VAL_W-1:0] read_value;
  logic [dss_pkg::ST_W-1:0]         status;
  logic [dss_pkg::CNT_W-1:0]        first_count;
  logic [dss_pkg::CNT_W-1:0]        second_count;

  modport source(output valid, read_value, status, first_count, second_count, input ready);
  modport sink(input valid, read_value, status, first_count, second_count, output ready);
endinterface

// ----- rtl/dual_stack_shared_memory.sv -----
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two LIFO stacks in one synchronous store, one growing up from entry 0 and
// one growing down from the top of the configured capacity.
//
//   channel   dir  payload                                         handshake
//   req_i     in   operation, push_value                           valid/ready
//   rsp_o     out  read_value, status, first_count, second_count   valid/ready
//   cfg       in   cfg_wdata_i (capacity)                          cfg_we_i
//
// One word per cycle is accepted while rsp_o is not stalled; its result is shown the cycle after.
// Each operation issues at most one store access, read data registered.
// Reset clears both fill levels and sets capacity to 1024; store not cleared.
// req_i.ready is high while the result register is empty or being taken.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dss_pkg::CNT_W-1:0] cfg_wdata_i,
  dss_req_if.sink                   req_i,
  dss_rsp_if.source                 rsp_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = dss_pkg::CNT_W;

  dss_pkg::ptr_resp_t resp;
  logic               fire;
  logic [CW+ADDR_W-1:0] idx_ext;
  logic [ADDR_W-1:0]  addr;
  logic [WORD_BITS-1:0] wdata;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic signed [WORD_BITS-1:0] rdata_q;

  logic                out_valid_q;
  logic                has_value_q;
  dss_pkg::status_e    status_q;
  logic [CW-1:0]       first_cnt_q, second_cnt_q;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  dss_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .op_i       (req_i.operation),
    .resp_o     (resp)
  );

  assign idx_ext = {{ADDR_W{1'b0}}, resp.index};
  assign addr    = idx_ext[ADDR_W-1:0];
  assign wdata   = WORD_BITS'($unsigned(req_i.push_value));

  always_ff @(posedge clk_i) begin
    if (fire && resp.mem_we) begin
      mem[addr] <= wdata;
    end
    if (fire && resp.mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      has_value_q  <= resp.has_value;
      status_q     <= resp.status;
      first_cnt_q  <= resp.first_cnt;
      second_cnt_q <= resp.second_cnt;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_value   = has_value_q ? dss_pkg::VAL_W'(rdata_q) : '0;
  assign rsp_o.status       = status_q;
  assign rsp_o.first_count  = first_cnt_q;
  assign rsp_o.second_count = second_cnt_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> out_valid_q)
    else $error("result word dropped under stall");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !fire)
    else $error("word accepted while result register is blocked");

  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted word produced no result");

endmodule

// ----- rtl/dss_ptr.sv -----
// ----------------------------------------------------------------------------
// dss_ptr
// Capacity and fill level registers, operation decode and store addressing.
// ----------------------------------------------------------------------------
module dss_ptr #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dss_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      fire_i,
  input  logic [dss_pkg::OP_W-1:0]  op_i,
  output dss_pkg::ptr_resp_t        resp_o
);

  localparam int unsigned CW = dss_pkg::CNT_W;

  logic [CW-1:0] cap_q, first_q, second_q;
  logic [CW-1:0] cap_eff;
  logic [CW:0]   fill_sum;
  logic          room;

  assign cap_eff  = (32'(cap_q) > DEPTH) ? CW'(DEPTH) : cap_q;
  assign fill_sum = {1'b0, first_q} + {1'b0, second_q};
  assign room     = fill_sum < {1'b0, cap_eff};

  always_comb begin
    resp_o            = '0;
    resp_o.status     = dss_pkg::ST_OK;
    resp_o.first_cnt  = first_q;
    resp_o.second_cnt = second_q;
    case (dss_pkg::op_e'(op_i))
      dss_pkg::OP_PUSH_FIRST: begin
        if (room) begin
          resp_o.mem_we    = 1'b1;
          resp_o.index     = first_q;
          resp_o.first_cnt = first_q + 1'b1;
        end else begin
          resp_o.status = dss_pkg::ST_OVERFLOW;
        end
      end
      dss_pkg::OP_PUSH_SECOND: begin
        if (room) begin
          resp_o.mem_we     = 1'b1;
          resp_o.second_cnt = second_q + 1'b1;
          resp_o.index      = cap_eff - resp_o.second_cnt;
        end else begin
          resp_o.status = dss_pkg::ST_OVERFLOW;
        end
      end
      dss_pkg::OP_POP_FIRST, dss_pkg::OP_PEEK_FIRST: begin
        if (first_q == '0) begin
          resp_o.status = dss_pkg::ST_EMPTY;
        end else begin
          resp_o.mem_re    = 1'b1;
          resp_o.has_value = 1'b1;
          resp_o.index     = first_q - 1'b1;
          if (dss_pkg::op_e'(op_i) == dss_pkg::OP_POP_FIRST) begin
            resp_o.first_cnt = first_q - 1'b1;
          end
        end
      end
      dss_pkg::OP_POP_SECOND, dss_pkg::OP_PEEK_SECOND: begin
        if (second_q == '0 || second_q > cap_eff) begin
          resp_o.status = dss_pkg::ST_EMPTY;
        end else begin
          resp_o.mem_re    = 1'b1;
          resp_o.has_value = 1'b1;
          resp_o.index     = cap_eff - second_q;
          if (dss_pkg::op_e'(op_i) == dss_pkg::OP_POP_SECOND) begin
            resp_o.second_cnt = second_q - 1'b1;
          end
        end
      end
      default: begin
        resp_o.status = dss_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= dss_pkg::CAP_RESET;
      first_q  <= '0;
      second_q <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cfg_wdata_i;
      first_q  <= '0;
      second_q <= '0;
    end else if (fire_i) begin
      first_q  <= resp_o.first_cnt;
      second_q <= resp_o.second_cnt;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_sum <= {1'b0, cap_eff})
    else $error("stack fill levels exceed capacity");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (first_q == '0 && second_q == '0))
    else $error("fill levels not cleared after capacity write");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(resp_o.mem_we && resp_o.mem_re))
    else $error("read and write issued together");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !fire_i) |=> ($stable(first_q) && $stable(second_q)))
    else $error("fill level moved without an operation");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for dual_stack_shared_memory. Operations are driven on the request
// channel with random gaps while the result channel back-pressures at random.
// Every accepted operation is applied to a local copy of both stacks and the
// shared store, and each result word is checked in order against it. The
// capacity register is rewritten between phases, across its full range.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam logic [dss_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [dss_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned REPORT_MAX = 10;

  typedef logic [dss_pkg::OP_W-1:0] op_code_t;

  typedef struct {
    logic [dss_pkg::OP_W-1:0]         op;
    logic signed [dss_pkg::VAL_W-1:0] value;
  } stack_op_t;

  typedef struct {
    logic signed [dss_pkg::VAL_W-1:0] read_value;
    dss_pkg::status_e                 status;
    logic [dss_pkg::CNT_W-1:0]        first_count;
    logic [dss_pkg::CNT_W-1:0]        second_count;
  } stack_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [dss_pkg::CNT_W-1:0] cfg_wdata_i;

  dss_req_if req_ch();
  dss_rsp_if rsp_ch();

  dual_stack_shared_memory uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  stack_op_t                        pending_ops[$];
  stack_result_t                    due_results[$];
  logic signed [dss_pkg::VAL_W-1:0] store_copy[STORE_DEPTH];
  int unsigned                      first_fill;
  int unsigned                      second_fill;
  logic [dss_pkg::CNT_W-1:0]        capacity_reg;
  int unsigned                      err_count;
  bit                               word_taken;
  bit                               calm;
  int unsigned                      send_gap;
  int unsigned                      take_gap;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic apply_stack_op(input logic [dss_pkg::OP_W-1:0] op,
                                input logic signed [dss_pkg::VAL_W-1:0] pv,
                                output stack_result_t res);
    int unsigned lim;
    bit          room;
    lim  = (capacity_reg > STORE_DEPTH) ? STORE_DEPTH : capacity_reg;
    room = (first_fill + second_fill) < lim;
    res.read_value = '0;
    res.status     = dss_pkg::ST_OK;
    case (op)
      dss_pkg::OP_PUSH_FIRST: begin
        if (room) begin
          store_copy[first_fill] = pv;
          first_fill++;
        end else begin
          res.status = dss_pkg::ST_OVERFLOW;
        end
      end
      dss_pkg::OP_PUSH_SECOND: begin
        if (room) begin
          second_fill++;
          store_copy[lim - second_fill] = pv;
        end else begin
          res.status = dss_pkg::ST_OVERFLOW;
        end
      end
      dss_pkg::OP_POP_FIRST, dss_pkg::OP_PEEK_FIRST: begin
        if (first_fill == 0) begin
          res.status = dss_pkg::ST_EMPTY;
        end else begin
          res.read_value = store_copy[first_fill - 1];
          if (op == dss_pkg::OP_POP_FIRST) first_fill--;
        end
      end
      dss_pkg::OP_POP_SECOND, dss_pkg::OP_PEEK_SECOND: begin
        if (second_fill == 0 || second_fill > lim) begin
          res.status = dss_pkg::ST_EMPTY;
        end else begin
          res.read_value = store_copy[lim - second_fill];
          if (op == dss_pkg::OP_POP_SECOND) second_fill--;
        end
      end
      default: ;
    endcase
    res.first_count  = first_fill[dss_pkg::CNT_W-1:0];
    res.second_count = second_fill[dss_pkg::CNT_W-1:0];
  endtask

  // drive the request channel
  always @(negedge clk_i) begin
    stack_op_t w;
    if (rst_ni && (!req_ch.valid || word_taken)) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        req_ch.valid <= 1'b0;
        send_gap = $urandom_range(1, 9) - 1;
      end else if (pending_ops.size() > 0) begin
        w = pending_ops.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= w.op;
        req_ch.push_value <= w.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // drive the result channel ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (take_gap > 0) begin
        rsp_ch.ready <= 1'b0;
        take_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        take_gap = $urandom_range(1, 9) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    stack_result_t want;
    stack_result_t fresh;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: result word with none pending: v=%0d st=%0d f=%0d s=%0d", $realtime,
                     rsp_ch.read_value, rsp_ch.status, rsp_ch.first_count, rsp_ch.second_count);
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.read_value !== want.read_value || rsp_ch.status !== want.status ||
              rsp_ch.first_count !== want.first_count ||
              rsp_ch.second_count !== want.second_count) begin
            err_count++;
            if (err_count <= REPORT_MAX)
              $display("%0t: mismatch exp v=%0d st=%0d f=%0d s=%0d got v=%0d st=%0d f=%0d s=%0d",
                       $realtime, want.read_value, want.status, want.first_count,
                       want.second_count, rsp_ch.read_value, rsp_ch.status,
                       rsp_ch.first_count, rsp_ch.second_count);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        apply_stack_op(req_ch.operation, req_ch.push_value, fresh);
        due_results.push_back(fresh);
        word_taken = 1'b1;
      end
    end
  end

  task automatic queue_op(input logic [dss_pkg::OP_W-1:0] op,
                          input logic signed [dss_pkg::VAL_W-1:0] value);
    stack_op_t w;
    w.op    = op;
    w.value = value;
    pending_ops.push_back(w);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || req_ch.valid || due_results.size() != 0);
  endtask

  task automatic set_capacity(input logic [dss_pkg::CNT_W-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg = cap;
    first_fill   = 0;
    second_fill  = 0;
  endtask

  task automatic random_ops(input int unsigned count, input int unsigned push_pct);
    logic signed [dss_pkg::VAL_W-1:0] v;
    int unsigned                      r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      v = $urandom;
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0: v = 32'sh0000_0000;
          1: v = -32'sd1;
          2: v = 32'sh7fff_ffff;
          default: v = 32'sh8000_0000;
        endcase
      end
      if (r < 3)
        queue_op(op_code_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), v);
      else if (r < 3 + push_pct)
        queue_op($urandom_range(0, 1) ? dss_pkg::OP_PUSH_SECOND : dss_pkg::OP_PUSH_FIRST, v);
      else
        queue_op(op_code_t'($urandom_range(dss_pkg::OP_POP_FIRST, dss_pkg::OP_PEEK_SECOND)),
                 v);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = dss_pkg::OP_PUSH_FIRST;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    capacity_reg      = dss_pkg::CAP_RESET;
    first_fill        = 0;
    second_fill       = 0;
    err_count         = 0;
    word_taken        = 1'b0;
    calm              = 1'b0;
    send_gap          = 0;
    take_gap          = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_op(dss_pkg::OP_POP_FIRST, 32'sd5);
    queue_op(dss_pkg::OP_POP_SECOND, 32'sd6);
    queue_op(dss_pkg::OP_PEEK_FIRST, 32'sd7);
    queue_op(dss_pkg::OP_PEEK_SECOND, 32'sd8);
    queue_op(dss_pkg::OP_PUSH_FIRST, 32'sh7fff_ffff);
    queue_op(dss_pkg::OP_PUSH_FIRST, 32'sh8000_0000);
    queue_op(dss_pkg::OP_PUSH_SECOND, 32'sh0000_0000);
    queue_op(dss_pkg::OP_PUSH_SECOND, -32'sd1);
    queue_op(dss_pkg::OP_PUSH_FIRST, 32'sh5555_5555);
    queue_op(dss_pkg::OP_PUSH_SECOND, 32'shaaaa_aaaa);
    queue_op(dss_pkg::OP_PEEK_FIRST, 32'sd0);
    queue_op(dss_pkg::OP_PEEK_SECOND, 32'sd0);
    queue_op(dss_pkg::OP_POP_FIRST, 32'sd0);
    queue_op(dss_pkg::OP_POP_FIRST, 32'sd0);
    queue_op(dss_pkg::OP_POP_SECOND, 32'sd0);
    queue_op(dss_pkg::OP_PEEK_SECOND, 32'sd0);
    queue_op(OP_SPARE_LO, 32'sd9);
    queue_op(OP_SPARE_HI, -32'sd9);

    set_capacity(11'd0);
    queue_op(dss_pkg::OP_PUSH_FIRST, 32'sd1);
    queue_op(dss_pkg::OP_PUSH_SECOND, 32'sd2);
    queue_op(dss_pkg::OP_POP_FIRST, 32'sd0);
    queue_op(dss_pkg::OP_PEEK_SECOND, 32'sd0);

    set_capacity(11'd1);
    queue_op(dss_pkg::OP_PUSH_FIRST, 32'sd11);
    queue_op(dss_pkg::OP_PUSH_SECOND, 32'sd12);
    queue_op(dss_pkg::OP_POP_FIRST, 32'sd0);
    queue_op(dss_pkg::OP_PUSH_SECOND, 32'sd13);
    queue_op(dss_pkg::OP_PEEK_SECOND, 32'sd0);

    set_capacity(11'd2);
    calm = 1'b1;
    random_ops(30, 70);
    random_ops(30, 30);
    set_capacity(11'd1);
    calm = 1'b0;
    random_ops(40, 50);
    set_capacity(11'd0);
    random_ops(12, 50);
    repeat (4) begin
      set_capacity(11'($urandom_range(3, 16)));
      random_ops(40, 70);
      random_ops(40, 25);
    end

    // clamp the capacity to the store depth
    set_capacity(11'd1025);
    random_ops(150, 90);
    random_ops(30, 10);
    set_capacity(11'd2047);
    random_ops(30, 70);
    random_ops(30, 30);
    set_capacity(11'($urandom_range(17, 200)));
    random_ops(60, 75);
    random_ops(30, 20);
    set_capacity(11'd1024);
    random_ops(40, 55);

    set_capacity(11'd4);
    calm = 1'b1;
    random_ops(30, 50);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (err_count == 0 && due_results.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dss_pkg.sv
rtl/dss_intf.sv
rtl/dss_ptr.sv
rtl/dual_stack_shared_memory.sv
bench/tb_top.sv
